/* rtl/grid_raycast_column_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the raycast column core
// Implication helpers sampled on clk, masked while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRID_RAYCAST_COLUMN_CORE_MACROS_SVH
`define GRID_RAYCAST_COLUMN_CORE_MACROS_SVH

// same-cycle implication
`define GRC_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("grc: same-cycle check failed");

// next-cycle implication
`define GRC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("grc: next-cycle check failed");

`endif

/* rtl/grc_pkg.sv */
// ----------------------------------------------------------------------------
// grc_pkg
// Shared widths, codes and types of the raycast column core.
// ----------------------------------------------------------------------------
package grc_pkg;

	localparam int COORD_W    = 16;
	localparam int ANGLE_W    = 16;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 6;
	localparam int GLYPH_W    = 3;
	localparam int STEP_W     = 8;
	localparam int HEIGHT_W   = 7;
	localparam int CFG_DATA_W = 64;
	localparam int SINE_W     = 16;
	localparam int POS_W      = 24;   // sample position, 1/163840 map unit
	localparam int CELL_W     = 4;    // map is at most 16 x 16
	localparam int DIV_W      = 26;   // column * fov
	localparam int DVSR_W     = 10;

	localparam int SAMPLE_UNIT = 163840;
	localparam int MAX_HEIGHT  = 64;
	localparam int HORIZON_K   = 20;

	typedef logic signed [SINE_W-1:0] sine_t;

	typedef enum logic [2:0] {
		CFG_WALL_0,
		CFG_WALL_1,
		CFG_WALL_2,
		CFG_WALL_3,
		CFG_SCREEN_HEIGHT,
		CFG_SCREEN_WIDTH,
		CFG_MAX_STEPS,
		CFG_FIELD_OF_VIEW
	} cfg_idx_t;

	typedef enum logic [GLYPH_W-1:0] {
		GLYPH_SPACE,
		GLYPH_LIGHT,
		GLYPH_MEDIUM,
		GLYPH_DARK,
		GLYPH_FULL
	} glyph_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

/* rtl/grc_if.sv */
// ----------------------------------------------------------------------------
// grc_if
// Valid/ready channels: viewer requests in, column glyphs out.
// ----------------------------------------------------------------------------
interface grc_req_if;
	import grc_pkg::*;

	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] viewer_x;
	logic [COORD_W-1:0] viewer_y;
	logic [ANGLE_W-1:0] heading;
	logic [COL_W-1:0]   column_index;

	modport source (output valid, viewer_x, viewer_y, heading, column_index, input ready);
	modport sink   (input valid, viewer_x, viewer_y, heading, column_index, output ready);
endinterface

interface grc_rsp_if;
	import grc_pkg::*;

	logic               valid;
	logic               ready;
	logic [ROW_W-1:0]   row_index;
	logic [GLYPH_W-1:0] glyph;
	logic [STEP_W-1:0]  hit_steps;
	logic               last_row;

	modport source (output valid, row_index, glyph, hit_steps, last_row, input ready);
	modport sink   (input valid, row_index, glyph, hit_steps, last_row, output ready);
endinterface

/* rtl/grc_div.sv */
// ----------------------------------------------------------------------------
// grc_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module grc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [grc_pkg::DIV_W-1:0]     dividend,
	input  logic [grc_pkg::DVSR_W-1:0]    divisor,
	output grc_pkg::div_status_t          status,
	output logic [grc_pkg::DIV_W-1:0]     quotient
);
	import grc_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_W-1:0]  dq_q;     // dividend shifts out, quotient shifts in
	logic [DVSR_W-1:0] rem_q;
	logic [DVSR_W-1:0] dvsr_q;

	logic [DVSR_W+1:0] diff;
	logic              ge;
	logic [DVSR_W-1:0] rem_next;

	assign diff     = {1'b0, rem_q, dq_q[DIV_W-1]} - {2'b0, dvsr_q};
	assign ge       = !diff[DVSR_W+1];
	assign rem_next = ge ? diff[DVSR_W-1:0] : {rem_q[DVSR_W-2:0], dq_q[DIV_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q   <= dividend;
			rem_q  <= '0;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DIV_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = dq_q;

endmodule

/* rtl/grc_sine_rom.sv */
// ----------------------------------------------------------------------------
// grc_sine_rom
// Q1.14 sine table, built at elaboration, registered read.
// ----------------------------------------------------------------------------
module grc_sine_rom #(
	parameter int ENTRIES = 1024
) (
	input  logic                       clk,
	input  logic [$clog2(ENTRIES)-1:0] addr,
	output grc_pkg::sine_t             data_q
);
	import grc_pkg::*;

	localparam logic [63:0] Q28_ONE     = 64'd1 << 28;
	localparam logic [63:0] HALF_PI_Q28 = 64'd421657428;

	// quarter-wave sine, r/16384 of a quarter turn; odd series to x^11 in Q4.28
	function automatic logic [SINE_W-1:0] quarter_sine(input logic [14:0] r);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		x  = (64'(r) * HALF_PI_Q28) >> 14;
		x2 = (x * x) >> 28;
		t  = Q28_ONE - x2 / 64'd110;
		t  = Q28_ONE - ((x2 * t) >> 28) / 64'd72;
		t  = Q28_ONE - ((x2 * t) >> 28) / 64'd42;
		t  = Q28_ONE - ((x2 * t) >> 28) / 64'd20;
		t  = Q28_ONE - ((x2 * t) >> 28) / 64'd6;
		s  = (x * t) >> 28;
		return SINE_W'((s + 64'd8192) >> 14);
	endfunction

	sine_t rom_w [ENTRIES];

	for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_entry
		localparam int unsigned PHASE = (gi * 65536) / ENTRIES;
		localparam int unsigned QUAD  = PHASE / 16384;
		localparam int unsigned FRAC  = PHASE % 16384;
		localparam int unsigned ARG   = (QUAD == 0 || QUAD == 2) ? FRAC : 16384 - FRAC;
		localparam logic [SINE_W-1:0] MAG = quarter_sine(15'(ARG));
		localparam logic [SINE_W-1:0] VAL = (QUAD < 2) ? MAG : SINE_W'(-MAG);
		assign rom_w[gi] = sine_t'(VAL);
	end

	always_ff @(posedge clk) begin
		data_q <= rom_w[addr];
	end

endmodule

/* rtl/grid_raycast_column_core.sv */
// ----------------------------------------------------------------------------
// grid_raycast_column_core: one raycaster column per request transaction.
// Each request runs two divides on the shared divider and marches one step a cycle;
// the rows then follow, one per output transaction.
// One request at a time; a new one is taken once the last row sits in the output register.
// arst_n clears the sequencer and output valid and loads the default room and view setup.
// ----------------------------------------------------------------------------
`include "grid_raycast_column_core_macros.svh"

module grid_raycast_column_core #(
	parameter int MAP_SIZE           = 16,
	parameter int SINE_TABLE_ENTRIES = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  grc_pkg::cfg_idx_t                 cfg_index,
	input  logic [grc_pkg::CFG_DATA_W-1:0]    cfg_data,
	grc_req_if.sink                           req,
	grc_rsp_if.source                         rsp
);
	import grc_pkg::*;

	// Flow of one request:
	//   IDLE      take transaction, start divider on column*fov / width
	//   DIV_ANG   wait for the angle quotient
	//   ROM_SIN   table read at the ray angle
	//   ROM_COS   table read a quarter turn on, sine captured
	//   ROM_LOAD  cosine captured, first sample (k = 1) formed
	//   MARCH     one 0.1-unit step per cycle until wall, off map or depth
	//   CEIL      start divider on |h*(k-20)| / 2k
	//   DIV_CEIL  wait, then signed ceiling and floor rows
	//   EMIT      one row per output transaction
	// The single restoring divider serves both divisions.

	localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES);
	localparam int NW    = $clog2(SINE_TABLE_ENTRIES + 1);
	localparam int PW    = ANGLE_W + NW;

	localparam logic signed [POS_W-1:0] POS_LOW  = -POS_W'(SAMPLE_UNIT);
	localparam logic signed [POS_W-1:0] POS_HIGH = POS_W'(MAP_SIZE * SAMPLE_UNIT);
	localparam logic [ANGLE_W-1:0]      QUARTER  = ANGLE_W'(16384);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV_ANG,
		S_ROM_SIN,
		S_ROM_COS,
		S_ROM_LOAD,
		S_MARCH,
		S_CEIL,
		S_DIV_CEIL,
		S_EMIT
	} state_t;

	// ---------------------------------------------------------------- config
	logic [CFG_DATA_W-1:0] wall_q [4];
	logic [HEIGHT_W-1:0]   height_q;
	logic [COL_W-1:0]      width_q;
	logic [STEP_W-1:0]     steps_q;
	logic [ANGLE_W-1:0]    fov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_q[0] <= 64'd9223794255762423807;
			wall_q[1] <= 64'd9223794255762391041;
			wall_q[2] <= 64'd9223794255762391041;
			wall_q[3] <= 64'd18446603342663745537;
			height_q  <= HEIGHT_W'(40);
			width_q   <= COL_W'(120);
			steps_q   <= STEP_W'(160);
			fov_q     <= ANGLE_W'(8192);
		end else if (cfg_we) begin
			case (cfg_index) inside
				CFG_WALL_0, CFG_WALL_1, CFG_WALL_2, CFG_WALL_3:
					wall_q[2'(cfg_index)] <= cfg_data;
				CFG_SCREEN_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				CFG_SCREEN_WIDTH:  width_q  <= cfg_data[COL_W-1:0];
				CFG_MAX_STEPS:     steps_q  <= cfg_data[STEP_W-1:0];
				CFG_FIELD_OF_VIEW: fov_q    <= cfg_data[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	// effective settings: zero height/width/depth read as 1, height capped at 64
	logic [HEIGHT_W-1:0] h_eff;
	logic [COL_W-1:0]    w_eff;
	logic [STEP_W-1:0]   d_eff;

	assign h_eff = (height_q == '0) ? HEIGHT_W'(1) :
		(height_q > HEIGHT_W'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT) : height_q;
	assign w_eff = (width_q == '0) ? COL_W'(1) : width_q;
	assign d_eff = (steps_q == '0) ? STEP_W'(1) : steps_q;

	// map bit (c, r) at r*16 + c
	logic [4*CFG_DATA_W-1:0] map_flat;
	assign map_flat = {wall_q[3], wall_q[2], wall_q[1], wall_q[0]};

	// ---------------------------------------------------------------- state
	state_t              state_q;
	logic [STEP_W-1:0]   k_q;
	logic [HEIGHT_W-1:0] row_q;
	logic                rsp_valid_q;
	logic [ROW_W-1:0]    rsp_row_q;
	logic [GLYPH_W-1:0]  rsp_glyph_q;
	logic [STEP_W-1:0]   rsp_steps_q;
	logic                rsp_last_q;

	// datapath
	logic [ANGLE_W-1:0]      ray_base_q;
	logic [ANGLE_W-1:0]      ray_q;
	sine_t                   sn_q;
	sine_t                   cs_q;
	logic signed [POS_W-1:0] px_q;
	logic signed [POS_W-1:0] py_q;
	logic [HEIGHT_W-1:0]     h_q;
	logic [STEP_W-1:0]       depth_q;
	glyph_t                  shade_q;
	logic signed [11:0]      ceil_q;
	logic signed [11:0]      floor_q;

	logic req_fire;
	assign req_fire  = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	// ---------------------------------------------------------------- divider
	div_status_t         div_st;
	logic                div_start;
	logic [DIV_W-1:0]    div_dividend;
	logic [DVSR_W-1:0]   div_divisor;
	logic [DIV_W-1:0]    div_quot;
	logic [DIV_W-1:0]    col_fov;
	logic [STEP_W-1:0]   k_dist;
	logic                k_near;
	logic [14:0]         ceil_mag;

	assign col_fov  = DIV_W'(req.column_index) * DIV_W'(fov_q);
	assign k_near   = (k_q < STEP_W'(HORIZON_K));
	assign k_dist   = k_near ? STEP_W'(HORIZON_K) - k_q : k_q - STEP_W'(HORIZON_K);
	assign ceil_mag = 15'(h_q) * 15'(k_dist);

	assign div_start    = req_fire || (state_q == S_CEIL);
	assign div_dividend = (state_q == S_CEIL) ? DIV_W'(ceil_mag) : col_fov;
	assign div_divisor  = (state_q == S_CEIL) ? {1'b0, k_q, 1'b0} : w_eff;

	grc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.status   (div_st),
		.quotient (div_quot)
	);

	// ---------------------------------------------------------------- sine table
	logic [ANGLE_W-1:0] rom_angle;
	logic [PW-1:0]      idx_prod;
	logic [IDX_W-1:0]   rom_addr;
	sine_t              rom_data;

	// index = angle * entries >> 16; cosine reads a quarter turn further on
	assign rom_angle = (state_q == S_ROM_COS) ? ray_q + QUARTER : ray_q;
	assign idx_prod  = PW'(rom_angle) * PW'(SINE_TABLE_ENTRIES);
	assign rom_addr  = idx_prod[ANGLE_W +: IDX_W];

	grc_sine_rom #(
		.ENTRIES (SINE_TABLE_ENTRIES)
	) u_rom (
		.clk    (clk),
		.addr   (rom_addr),
		.data_q (rom_data)
	);

	// ---------------------------------------------------------------- march step
	// cell = trunc(p / 163840) = (p >> 15) / 5; small negatives land in cell 0
	function automatic logic [CELL_W-1:0] cell_of(input logic signed [POS_W-1:0] p);
		logic [14:0] prod;
		prod = 15'(p[21:15]) * 15'(205);
		return p[POS_W-1] ? '0 : prod[13:10];
	endfunction

	logic              in_map;
	logic [CELL_W-1:0] cx;
	logic [CELL_W-1:0] cy;
	logic              wall_hit;
	logic              march_stop;

	assign in_map     = (px_q > POS_LOW) && (px_q < POS_HIGH) &&
		(py_q > POS_LOW) && (py_q < POS_HIGH);
	assign cx         = cell_of(px_q);
	assign cy         = cell_of(py_q);
	assign wall_hit   = map_flat[{cy, cx}];
	assign march_stop = !in_map || wall_hit || (k_q == depth_q);

	// ---------------------------------------------------------------- shade
	glyph_t            shade;
	logic [STEP_W+1:0] k1;
	logic [STEP_W+1:0] k2;
	logic [STEP_W+1:0] k3;
	logic [STEP_W+1:0] k4;
	logic [STEP_W+1:0] dd;

	assign k1 = {2'b0, k_q};
	assign k2 = {1'b0, k_q, 1'b0};
	assign k4 = {k_q, 2'b0};
	assign k3 = k1 + k2;
	assign dd = {2'b0, depth_q};

	always_comb begin
		if (k4 <= dd)      shade = GLYPH_FULL;
		else if (k3 <= dd) shade = GLYPH_DARK;
		else if (k2 <= dd) shade = GLYPH_MEDIUM;
		else if (k1 <= dd) shade = GLYPH_LIGHT;
		else               shade = GLYPH_SPACE;
	end

	// ceiling rounds toward zero: divide magnitudes, then restore the sign
	logic signed [11:0] ceil_val;
	logic signed [11:0] floor_val;
	assign ceil_val  = k_near ? -$signed(12'(div_quot[10:0])) : $signed(12'(div_quot[10:0]));
	assign floor_val = $signed(12'(h_q)) - ceil_val;

	// ---------------------------------------------------------------- row output
	logic               row_lit;
	logic               row_last;
	logic               rsp_load;
	logic signed [11:0] row_s;

	assign row_s    = $signed(12'(row_q));
	assign row_lit  = (row_s > ceil_q) && (row_s <= floor_q);
	assign row_last = (row_q == h_q - HEIGHT_W'(1));
	assign rsp_load = (state_q == S_EMIT) && (!rsp_valid_q || rsp.ready);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			row_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_row_q   <= '0;
			rsp_glyph_q <= '0;
			rsp_steps_q <= '0;
			rsp_last_q  <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						state_q <= S_DIV_ANG;
					end
				end
				S_DIV_ANG: begin
					if (div_st.done) begin
						state_q <= S_ROM_SIN;
					end
				end
				S_ROM_SIN:  state_q <= S_ROM_COS;
				S_ROM_COS:  state_q <= S_ROM_LOAD;
				S_ROM_LOAD: begin
					k_q     <= STEP_W'(1);
					state_q <= S_MARCH;
				end
				S_MARCH: begin
					if (!in_map) begin
						k_q     <= depth_q;
						state_q <= S_CEIL;
					end else if (march_stop) begin
						state_q <= S_CEIL;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_CEIL: state_q <= S_DIV_CEIL;
				S_DIV_CEIL: begin
					if (div_st.done) begin
						row_q   <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (rsp_load) begin
						rsp_valid_q <= 1'b1;
						rsp_row_q   <= row_q[ROW_W-1:0];
						rsp_glyph_q <= row_lit ? shade_q : GLYPH_SPACE;
						rsp_steps_q <= k_q;
						rsp_last_q  <= row_last;
						row_q       <= row_q + 1'b1;
						if (row_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			// viewer position scaled by 40 into sample units
			px_q       <= $signed(POS_W'({req.viewer_x, 5'b0}) + POS_W'({req.viewer_x, 3'b0}));
			py_q       <= $signed(POS_W'({req.viewer_y, 5'b0}) + POS_W'({req.viewer_y, 3'b0}));
			ray_base_q <= req.heading - (fov_q >> 1);
			h_q        <= h_eff;
			depth_q    <= d_eff;
		end
		if (state_q == S_DIV_ANG && div_st.done) begin
			ray_q <= ray_base_q + div_quot[ANGLE_W-1:0];
		end
		if (state_q == S_ROM_COS) begin
			sn_q <= rom_data;
		end
		if (state_q == S_ROM_LOAD) begin
			cs_q <= rom_data;
			px_q <= px_q + POS_W'(rom_data);
			py_q <= py_q + POS_W'(sn_q);
		end
		if (state_q == S_MARCH && !march_stop) begin
			px_q <= px_q + POS_W'(cs_q);
			py_q <= py_q + POS_W'(sn_q);
		end
		if (state_q == S_CEIL) begin
			shade_q <= shade;
		end
		if (state_q == S_DIV_CEIL && div_st.done) begin
			ceil_q  <= ceil_val;
			floor_q <= floor_val;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.row_index = rsp_row_q;
	assign rsp.glyph     = rsp_glyph_q;
	assign rsp.hit_steps = rsp_steps_q;
	assign rsp.last_row  = rsp_last_q;

	// ---------------------------------------------------------------- checks
	`GRC_ASSERT_NEXT(a_busy_after_req, req.valid && req.ready, !req.ready)
	`GRC_ASSERT_IMP(a_march_k_range, state_q == S_MARCH, k_q != '0 && k_q <= depth_q)
	`GRC_ASSERT_IMP(a_div_done_owned, div_st.done, state_q == S_DIV_ANG || state_q == S_DIV_CEIL)
	`GRC_ASSERT_IMP(a_emit_row_bound, state_q == S_EMIT, row_q < h_q)
	`GRC_ASSERT_IMP(a_div_idle_in_emit, state_q == S_EMIT, !div_st.busy)

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: raycast column core testbench
// Drives viewer requests through a valid/ready channel and checks every row
// transaction against a cycle-free column renderer kept in this file. Short
// directed runs cover the register extremes; randomised rooms, views and
// channel stalls make up the rest.
// ----------------------------------------------------------------------------
module tb;
	import grc_pkg::*;

	localparam int MAP_CELLS    = 16;
	localparam int SINE_ENTRIES = 1024;
	localparam int CYCLE_LIMIT  = 3000000;
	localparam int DRAIN_CYCLES = 400;   // march depth + divides + a full column
	localparam int PRINT_LIMIT  = 60;
	localparam logic [63:0] Q28_ONE = 64'd1 << 28;
	localparam logic [63:0] HALF_PI_Q28 = 64'd421657428;

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [ANGLE_W-1:0] heading;
		logic [COL_W-1:0]   column;
	} view_t;

	typedef struct {
		logic [ROW_W-1:0]  row_index;
		glyph_t            glyph;
		logic [STEP_W-1:0] hit_steps;
		logic              last_row;
	} row_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	grc_req_if req_ch ();
	grc_rsp_if rsp_ch ();

	grid_raycast_column_core #(
		.MAP_SIZE          (MAP_CELLS),
		.SINE_TABLE_ENTRIES(SINE_ENTRIES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the register file, updated as each write is issued
	logic [63:0]         wall_map [4];
	logic [HEIGHT_W-1:0] height_cfg;
	logic [COL_W-1:0]    width_cfg;
	logic [STEP_W-1:0]   depth_cfg;
	logic [ANGLE_W-1:0]  fov_cfg;

	view_t       pending_views [$];
	row_result_t expected_rows [$];
	int          views_queued;
	int          views_taken;
	int          errors;
	int          cycle_count;
	int          send_gap;
	int          take_gap;
	bit          steady;         // no idling on either side
	logic [63:0] room [4];

	// --------------------------------------------------------------------
	// Column renderer
	// --------------------------------------------------------------------

	// quarter-wave sine, odd series to x^11 in Q4.28, rounded to Q1.14
	function automatic int quarter_wave_sine(input int unsigned r);
		logic [63:0] x, x2, t, s;
		x  = (64'(r) * HALF_PI_Q28) >> 14;
		x2 = (x * x) >> 28;
		t  = Q28_ONE - x2 / 110;
		t  = Q28_ONE - ((x2 * t) >> 28) / 72;
		t  = Q28_ONE - ((x2 * t) >> 28) / 42;
		t  = Q28_ONE - ((x2 * t) >> 28) / 20;
		t  = Q28_ONE - ((x2 * t) >> 28) / 6;
		s  = (x * t) >> 28;
		return int'((s + 64'd8192) >> 14);
	endfunction

	// table lookup: angle quantised to the table, then folded into a quarter
	function automatic int ray_sine(input logic [ANGLE_W-1:0] angle);
		int unsigned a, idx, phase, quad, frac;
		a     = angle;
		idx   = (a * SINE_ENTRIES) >> 16;
		phase = ((idx * 65536) / SINE_ENTRIES) & 32'hFFFF;
		quad  = phase >> 14;
		frac  = phase & 32'h3FFF;
		case (quad)
			0: return quarter_wave_sine(frac);
			1: return quarter_wave_sine(16384 - frac);
			2: return -quarter_wave_sine(frac);
			default: return -quarter_wave_sine(16384 - frac);
		endcase
	endfunction

	function automatic void predict_column(input view_t v);
		int          h, depth, k, sn, cs;
		int unsigned w, ray;
		longint      px, py, cx, cy, ceil_row, floor_row;
		bit          stop;
		glyph_t      shade;
		row_result_t r;
		// degenerate register values are clamped rather than rejected
		h     = (height_cfg == 0) ? 1 : (height_cfg > MAX_HEIGHT) ? MAX_HEIGHT : height_cfg;
		w     = (width_cfg == 0) ? 1 : width_cfg;
		depth = (depth_cfg == 0) ? 1 : depth_cfg;
		// columns past the width simply keep turning; no error
		ray = (32'(v.heading) - 32'(fov_cfg >> 1)
			+ (32'(v.column) * 32'(fov_cfg)) / w) & 32'hFFFF;
		sn = ray_sine(16'(ray));
		cs = ray_sine(16'(ray + 16384));
		k    = 0;
		stop = 1'b0;
		while (!stop && k < depth) begin
			k++;
			px = longint'(v.x) * 40 + longint'(cs) * k;
			py = longint'(v.y) * 40 + longint'(sn) * k;
			// division truncates toward zero: just left of the origin is still cell 0
			cx = px / SAMPLE_UNIT;
			cy = py / SAMPLE_UNIT;
			if (cx < 0 || cx >= MAP_CELLS || cy < 0 || cy >= MAP_CELLS) begin
				stop = 1'b1;
				k    = depth;   // leaving the map reads as the far limit
			end else if (wall_map[cy / 4][(cy % 4) * 16 + cx]) begin
				stop = 1'b1;
			end
		end
		ceil_row  = (longint'(h) * (k - HORIZON_K)) / (2 * k);
		floor_row = h - ceil_row;
		if (4 * k <= depth)
			shade = GLYPH_FULL;
		else if (3 * k <= depth)
			shade = GLYPH_DARK;
		else if (2 * k <= depth)
			shade = GLYPH_MEDIUM;
		else if (k <= depth)
			shade = GLYPH_LIGHT;
		else
			shade = GLYPH_SPACE;
		for (int y = 0; y < h; y++) begin
			r.row_index = ROW_W'(y);
			r.glyph     = (y > ceil_row && y <= floor_row) ? shade : GLYPH_SPACE;
			r.hit_steps = k[STEP_W-1:0];
			r.last_row  = (y == h - 1);
			expected_rows.push_back(r);
		end
	endfunction

	// --------------------------------------------------------------------
	// Stimulus helpers
	// --------------------------------------------------------------------

	function automatic void push_view(input logic [15:0] x, y, heading, input logic [9:0] column);
		view_t v;
		v.x       = x;
		v.y       = y;
		v.heading = heading;
		v.column  = column;
		pending_views.push_back(v);
		views_queued++;
	endfunction

	// mostly a viewer inside the room looking across the screen; some noise
	function automatic void push_random_view();
		int pick, w;
		pick = $urandom_range(0, 9);
		w    = (width_cfg == 0) ? 1 : width_cfg;
		if (pick == 0)
			push_view(16'($urandom), 16'($urandom), 16'($urandom), 10'($urandom));
		else
			push_view(16'($urandom_range(16'h1000, 16'hEFFF)),
				16'($urandom_range(16'h1000, 16'hEFFF)), 16'($urandom),
				(pick == 1) ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(0, w - 1)));
	endfunction

	// bordered 16x16 room with sparse pillars, or pure noise
	function automatic void build_room(input bit noise);
		logic [15:0] bits;
		for (int r = 0; r < MAP_CELLS; r++) begin
			if (noise)
				bits = 16'($urandom);
			else if (r == 0 || r == MAP_CELLS - 1)
				bits = 16'hFFFF;
			else
				bits = 16'h8001 | (16'($urandom) & 16'($urandom) & 16'($urandom));
			room[r / 4][(r % 4) * 16 +: 16] = bits;
		end
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_WALL_0:        wall_map[0] = val;
			CFG_WALL_1:        wall_map[1] = val;
			CFG_WALL_2:        wall_map[2] = val;
			CFG_WALL_3:        wall_map[3] = val;
			CFG_SCREEN_HEIGHT: height_cfg  = val[HEIGHT_W-1:0];
			CFG_SCREEN_WIDTH:  width_cfg   = val[COL_W-1:0];
			CFG_MAX_STEPS:     depth_cfg   = val[STEP_W-1:0];
			CFG_FIELD_OF_VIEW: fov_cfg     = val[ANGLE_W-1:0];
			default: ;
		endcase
	endtask

	// full register set; unused upper data bits carry junk
	task automatic configure(input logic [63:0] w0, w1, w2, w3, input int h, w, d, f);
		logic [63:0] junk;
		write_reg(CFG_WALL_0, w0);
		write_reg(CFG_WALL_1, w1);
		write_reg(CFG_WALL_2, w2);
		write_reg(CFG_WALL_3, w3);
		junk = {$urandom, $urandom};
		write_reg(CFG_SCREEN_HEIGHT, {junk[63:HEIGHT_W], 7'(h)});
		write_reg(CFG_SCREEN_WIDTH, {junk[63:COL_W], 10'(w)});
		write_reg(CFG_MAX_STEPS, {junk[63:STEP_W], 8'(d)});
		write_reg(CFG_FIELD_OF_VIEW, {junk[63:ANGLE_W], 16'(f)});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// sender holds off until every queued view has been rendered
	task automatic wait_idle();
		do
			@(posedge clk);
		while (views_taken != views_queued || expected_rows.size() != 0);
	endtask

	task automatic check_field(input string what, input logic [7:0] want, got);
		if (got !== want) begin
			if (errors < PRINT_LIMIT)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			errors++;
		end
	endtask

	// --------------------------------------------------------------------
	// Request driver: bursts of idling between transactions
	// --------------------------------------------------------------------
	always @(posedge clk) begin : drive_requests
		view_t v;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (send_gap > 0) begin
				send_gap     <= send_gap - 1;
				req_ch.valid <= 1'b0;
			end else if (pending_views.size() > 0) begin
				v = pending_views.pop_front();
				req_ch.valid        <= 1'b1;
				req_ch.viewer_x     <= v.x;
				req_ch.viewer_y     <= v.y;
				req_ch.heading      <= v.heading;
				req_ch.column_index <= v.column;
				if (!steady && $urandom_range(0, 9) == 0)
					send_gap <= $urandom_range(1, 13);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// --------------------------------------------------------------------
	// Row sink: ready drops in random bursts unless steady is set; then it is high in all cycles
	// --------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (take_gap > 0) begin
			take_gap     <= take_gap - 1;
			rsp_ch.ready <= 1'b0;
		end else if (!steady && $urandom_range(0, 15) == 0) begin
			take_gap     <= $urandom_range(0, 12);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// --------------------------------------------------------------------
	// Monitor: predict on each accepted request, check each row in order
	// --------------------------------------------------------------------
	always @(posedge clk) begin : watch_channels
		view_t       v;
		row_result_t want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				v.x       = req_ch.viewer_x;
				v.y       = req_ch.viewer_y;
				v.heading = req_ch.heading;
				v.column  = req_ch.column_index;
				predict_column(v);
				views_taken++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rows.size() == 0) begin
					if (errors < PRINT_LIMIT)
						$display("%0t: unexpected row transaction, expected none, actual row %0d",
							$time, rsp_ch.row_index);
					errors++;
				end else begin
					want = expected_rows.pop_front();
					check_field("row_index", want.row_index, rsp_ch.row_index);
					check_field("glyph", want.glyph, rsp_ch.glyph);
					check_field("hit_steps", want.hit_steps, rsp_ch.hit_steps);
					check_field("last_row", want.last_row, rsp_ch.last_row);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// --------------------------------------------------------------------
	// Sequence of the run
	// --------------------------------------------------------------------
	initial begin
		int h, w, d, f;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = CFG_WALL_0;
		cfg_data            = '0;
		req_ch.valid        = 1'b0;
		req_ch.viewer_x     = '0;
		req_ch.viewer_y     = '0;
		req_ch.heading      = '0;
		req_ch.column_index = '0;
		rsp_ch.ready        = 1'b0;
		views_queued = 0;
		views_taken  = 0;
		errors       = 0;
		cycle_count  = 0;
		send_gap     = 0;
		take_gap     = 0;
		steady       = 1'b0;
		// default room and view after reset
		wall_map[0] = 64'h8001_8001_8001_FFFF;
		wall_map[1] = 64'h8001_8001_8001_8001;
		wall_map[2] = 64'h8001_8001_8001_8001;
		wall_map[3] = 64'hFFFF_8001_8001_8001;
		height_cfg  = 40;
		width_cfg   = 120;
		depth_cfg   = 160;
		fov_cfg     = 8192;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default room: cardinal headings, edge columns, field extremes
		push_view(16'h8800, 16'h8800, 16'h0000, 10'd60);
		push_view(16'h8800, 16'h8800, 16'h4000, 10'd60);
		push_view(16'h8800, 16'h8800, 16'h8000, 10'd60);
		push_view(16'h8800, 16'h8800, 16'hC000, 10'd60);
		push_view(16'h8800, 16'h8800, 16'hFFFF, 10'd0);
		push_view(16'h1800, 16'h1800, 16'h8000, 10'd119);
		push_view(16'h8800, 16'h8800, 16'h2000, 10'd120);   // column past width
		push_view(16'h8800, 16'h8800, 16'h0000, 10'd1023);
		push_view(16'h0000, 16'h0000, 16'h0000, 10'd0);     // standing in a wall
		push_view(16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1023);
		push_view(16'hE800, 16'h2800, 16'h0000, 10'd60);
		push_view(16'h1000, 16'hEFFF, 16'h4000, 10'd30);
		push_view(16'h5555, 16'hAAAA, 16'hAAAA, 10'h155);
		push_view(16'hAAAA, 16'h5555, 16'h5555, 10'h2AA);
		wait_idle();

		// empty map, zero height, zero width, deepest march, no field of view:
		// every ray runs off the map, some through the small negative range
		configure('0, '0, '0, '0, 0, 0, 255, 0);
		push_view(16'h0010, 16'h8000, 16'h8000, 10'd0);
		push_view(16'h8000, 16'h0010, 16'hC000, 10'd5);
		push_view(16'h8800, 16'h8800, 16'h1234, 10'd1023);
		push_view(16'hFFFF, 16'h0000, 16'h0000, 10'd0);
		wait_idle();

		// solid map, height saturates, widest screen, zero depth, full turn of view
		configure('1, '1, '1, '1, 127, 1023, 0, 65535);
		push_view(16'h8800, 16'h8800, 16'h0000, 10'd0);
		push_view(16'h0000, 16'hFFFF, 16'h8000, 10'd1023);
		push_view(16'h4000, 16'h4000, 16'h4000, 10'd512);
		wait_idle();

		// randomised rooms and views; the last phase runs without idling
		for (int p = 0; p < 6; p++) begin
			build_room(p == 2);
			h = (p == 1) ? 64 : (p == 4) ? $urandom_range(65, 127) : $urandom_range(1, 40);
			w = (p == 2) ? 1 : $urandom_range(1, 1023);
			d = (p == 0) ? 255 : (p == 3) ? 1 : (p == 5) ? 160 : $urandom_range(1, 255);
			f = $urandom_range(0, 65535);
			configure(room[0], room[1], room[2], room[3], h, w, d, f);
			if (p == 5)
				steady = 1'b1;
			repeat (55) push_random_view();
			wait_idle();
		end

		// anything arriving now is surplus
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
